### hw/rtl/plt_pkg.sv
// shared constants, codes and types of the positional list table
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

    localparam int CAPACITY = 64;
    localparam int HANDLE_W = 32;
    localparam int IDX_W    = 8;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GROUP    = 8;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_SWAP   = 3'd4
    } plt_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } plt_status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SET,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SWAP
    } plt_cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TREE,
        S_FINISH
    } plt_state_t;

    typedef struct packed {
        plt_cell_op_t          op;
        logic                  capture;
        logic [IDX_W-1:0]      pos;
        logic [IDX_W-1:0]      opos;
        logic [HANDLE_W-1:0]   hin;
        logic [HANDLE_W-1:0]   swap_a;
        logic [HANDLE_W-1:0]   swap_b;
    } plt_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/plt_cell.sv
// one list cell: holds one entry, shifts with its neighbors, captures reads
`timescale 1ns / 1ps
`default_nettype none

module plt_cell
    import plt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic [IDX_W-1:0]    idx,
    input  wire plt_ctl_t            ctl,
    input  wire logic [HANDLE_W-1:0] left,
    input  wire logic [HANDLE_W-1:0] right,
    output logic      [HANDLE_W-1:0] data,
    output logic      [HANDLE_W-1:0] cap_a,
    output logic      [HANDLE_W-1:0] cap_b
);

    logic [HANDLE_W-1:0] data_reg;
    logic [HANDLE_W-1:0] data_next;
    logic [HANDLE_W-1:0] cap_a_reg;
    logic [HANDLE_W-1:0] cap_a_next;
    logic [HANDLE_W-1:0] cap_b_reg;
    logic [HANDLE_W-1:0] cap_b_next;
    logic                hit_pos;
    logic                hit_opos;
    logic                above;

    assign hit_pos  = (idx == ctl.pos);
    assign hit_opos = (idx == ctl.opos);
    assign above    = (idx > ctl.pos);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_SET:
            begin
                if (hit_pos)
                begin
                    data_next = ctl.hin;
                end
            end
            CELL_INSERT:
            begin
                if (hit_pos)
                begin
                    data_next = ctl.hin;
                end
                else if (above)
                begin
                    data_next = left;
                end
            end
            CELL_REMOVE:
            begin
                if (hit_pos || above)
                begin
                    data_next = right;
                end
            end
            CELL_SWAP:
            begin
                if (hit_pos)
                begin
                    data_next = ctl.swap_b;
                end
                else if (hit_opos)
                begin
                    data_next = ctl.swap_a;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_comb
    begin
        cap_a_next = cap_a_reg;
        cap_b_next = cap_b_reg;
        if (ctl.capture)
        begin
            cap_a_next = hit_pos  ? data_reg : '0;
            cap_b_next = hit_opos ? data_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        cap_a_reg <= cap_a_next;
        cap_b_reg <= cap_b_next;
    end

    assign data  = data_reg;
    assign cap_a = cap_a_reg;
    assign cap_b = cap_b_reg;

endmodule

`default_nettype wire

### hw/rtl/plt_or_tree.sv
// two-level or tree that merges the one-hot captured cell words
`timescale 1ns / 1ps
`default_nettype none

module plt_or_tree
    import plt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [HANDLE_W-1:0] word [CAPACITY],
    output logic      [HANDLE_W-1:0] result
);

    logic [HANDLE_W-1:0] part      [NGROUP][GROUP];
    logic [HANDLE_W-1:0] grp_reg   [NGROUP];
    logic [HANDLE_W-1:0] grp_next  [NGROUP];

    for (genvar g = 0; g < NGROUP; g++)
    begin : g_grp
        for (genvar k = 0; k < GROUP; k++)
        begin : g_leaf
            if (g * GROUP + k < CAPACITY)
            begin : g_used
                assign part[g][k] = word[g * GROUP + k];
            end
            else
            begin : g_pad
                assign part[g][k] = '0;
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_next[g] = grp_reg[g];
            if (en)
            begin
                grp_next[g] = '0;
                for (int k = 0; k < GROUP; k++)
                begin
                    grp_next[g] = grp_next[g] | part[g][k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            result = result | grp_reg[g];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/positional_list_table_top.sv
// top level of the positional list table: command sequencer, cell row, read trees
//
//   channel   direction  handshake              payload
//   command   in         in_valid / in_stall    command, position, other_position, handle_in
//   result    out        out_valid / out_stall  status, handle_out, placed_at, entry_count
//
// a command goes from transfer to result register through accept, cell update and capture,
// group or stage, final or with the swap write, and result load
// the or stages come from the two-level read tree over the cell row, registered at its group level
// in the update step, insert shifts the cells above the position and remove those from it on
// reset clears state, entry count and out_valid; cells are undefined until written
// a stalled result holds the sequencer in its last step; no new command is taken
`timescale 1ns / 1ps
`default_nettype none

module positional_list_table_top
    import plt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [IDX_W-1:0]    position,
    input  wire logic [IDX_W-1:0]    other_position,
    input  wire logic [HANDLE_W-1:0] handle_in,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [HANDLE_W-1:0]      handle_out,
    output logic [IDX_W-1:0]         placed_at,
    output logic [IDX_W-1:0]         entry_count
);

    plt_state_t            state_reg;
    plt_state_t            state_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [CMD_W-1:0]      cmd_next;
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      pos_next;
    logic [IDX_W-1:0]      opos_reg;
    logic [IDX_W-1:0]      opos_next;
    logic [HANDLE_W-1:0]   hin_reg;
    logic [HANDLE_W-1:0]   hin_next;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [STATUS_W-1:0]   st_reg;
    logic [STATUS_W-1:0]   st_next;
    logic [IDX_W-1:0]      placed_reg;
    logic [IDX_W-1:0]      placed_next;
    logic                  hout_en_reg;
    logic                  hout_en_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [STATUS_W-1:0]   out_status_next;
    logic [HANDLE_W-1:0]   out_handle_reg;
    logic [HANDLE_W-1:0]   out_handle_next;
    logic [IDX_W-1:0]      out_placed_reg;
    logic [IDX_W-1:0]      out_placed_next;
    logic [IDX_W-1:0]      out_count_reg;
    logic [IDX_W-1:0]      out_count_next;

    logic                  in_xfer;
    logic                  out_free;
    logic                  swap_ok;
    logic [IDX_W:0]        pos_ext;
    logic [IDX_W:0]        opos_ext;
    logic [IDX_W:0]        fill_ext;
    logic                  pos_bad;
    logic                  opos_bad;
    logic                  full;
    logic [IDX_W-1:0]      clamp;

    plt_status_t           exec_status;
    plt_cell_op_t          exec_op;
    logic [IDX_W-1:0]      exec_pos;
    logic [CNT_W-1:0]      exec_fill;
    logic                  exec_hout;
    logic [IDX_W-1:0]      exec_placed;

    plt_ctl_t              ctl;
    logic                  tree_en;
    logic [HANDLE_W-1:0]   tree_a;
    logic [HANDLE_W-1:0]   tree_b;
    logic [HANDLE_W-1:0]   cell_data [CAPACITY];
    logic [HANDLE_W-1:0]   cell_cap_a [CAPACITY];
    logic [HANDLE_W-1:0]   cell_cap_b [CAPACITY];

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign swap_ok  = (cmd_reg == CMD_SWAP) && (st_reg == ST_OK);

    assign pos_ext  = {1'b0, pos_reg};
    assign opos_ext = {1'b0, opos_reg};
    assign fill_ext = (IDX_W + 1)'(fill_reg);
    assign pos_bad  = (pos_ext >= fill_ext);
    assign opos_bad = (opos_ext >= fill_ext);
    assign full     = (fill_ext == (IDX_W + 1)'(CAPACITY));
    assign clamp    = pos_bad ? fill_ext[IDX_W-1:0] : pos_reg;

    // command decode against the current count
    always_comb
    begin
        exec_status = ST_OK;
        exec_op     = CELL_HOLD;
        exec_pos    = pos_reg;
        exec_fill   = fill_reg;
        exec_hout   = 1'b0;
        exec_placed = '0;
        case (cmd_reg)
            CMD_GET:
            begin
                if (pos_bad)
                begin
                    exec_status = ST_BAD_INDEX;
                end
                else
                begin
                    exec_hout = 1'b1;
                end
            end
            CMD_SET:
            begin
                if (pos_bad)
                begin
                    exec_status = ST_BAD_INDEX;
                end
                else
                begin
                    exec_op   = CELL_SET;
                    exec_hout = 1'b1;
                end
            end
            CMD_INSERT:
            begin
                if (full)
                begin
                    exec_status = ST_FULL;
                end
                else
                begin
                    exec_op     = CELL_INSERT;
                    exec_pos    = clamp;
                    exec_placed = clamp;
                    exec_fill   = fill_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (pos_bad)
                begin
                    exec_status = ST_BAD_INDEX;
                end
                else
                begin
                    exec_op   = CELL_REMOVE;
                    exec_hout = 1'b1;
                    exec_fill = fill_reg - CNT_W'(1);
                end
            end
            CMD_SWAP:
            begin
                if (pos_bad || opos_bad)
                begin
                    exec_status = ST_BAD_INDEX;
                end
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_TREE;
            end
            S_TREE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall    = 1'b1;
        tree_en     = 1'b0;
        ctl.op      = CELL_HOLD;
        ctl.capture = 1'b0;
        ctl.pos     = pos_reg;
        ctl.opos    = opos_reg;
        ctl.hin     = hin_reg;
        ctl.swap_a  = tree_a;
        ctl.swap_b  = tree_b;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_EXEC:
            begin
                ctl.op      = exec_op;
                ctl.capture = 1'b1;
                ctl.pos     = exec_pos;
            end
            S_TREE:
            begin
                tree_en = 1'b1;
            end
            S_FINISH:
            begin
                if (swap_ok)
                begin
                    ctl.op = CELL_SWAP;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // command and result registers
    always_comb
    begin
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        opos_next       = opos_reg;
        hin_next        = hin_reg;
        fill_next       = fill_reg;
        st_next         = st_reg;
        placed_next     = placed_reg;
        hout_en_next    = hout_en_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_placed_next = out_placed_reg;
        out_count_next  = out_count_reg;
        if (in_xfer)
        begin
            cmd_next  = command;
            pos_next  = position;
            opos_next = other_position;
            hin_next  = handle_in;
        end
        if (state_reg == S_EXEC)
        begin
            fill_next    = exec_fill;
            st_next      = exec_status;
            placed_next  = exec_placed;
            hout_en_next = exec_hout;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = st_reg;
            out_handle_next = hout_en_reg ? tree_a : '0;
            out_placed_next = placed_reg;
            out_count_next  = fill_ext[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        opos_reg       <= opos_next;
        hin_reg        <= hin_next;
        st_reg         <= st_next;
        placed_reg     <= placed_next;
        hout_en_reg    <= hout_en_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_placed_reg <= out_placed_next;
        out_count_reg  <= out_count_next;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [HANDLE_W-1:0] left_data;
        logic [HANDLE_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_inner_l
            assign left_data = cell_data[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_inner_r
            assign right_data = cell_data[i + 1];
        end

        plt_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(i)),
            .ctl   (ctl),
            .left  (left_data),
            .right (right_data),
            .data  (cell_data[i]),
            .cap_a (cell_cap_a[i]),
            .cap_b (cell_cap_b[i])
        );
    end

    plt_or_tree u_tree_a (
        .clk    (clk),
        .en     (tree_en),
        .word   (cell_cap_a),
        .result (tree_a)
    );

    plt_or_tree u_tree_b (
        .clk    (clk),
        .en     (tree_en),
        .word   (cell_cap_b),
        .result (tree_b)
    );

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign handle_out  = out_handle_reg;
    assign placed_at   = out_placed_reg;
    assign entry_count = out_count_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_ext <= (IDX_W + 1)'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_EXEC))
        else $error("accepted command did not start execution");

    a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_status_reg != 2'd3)
            && ((IDX_W + 1)'(out_count_reg) <= (IDX_W + 1)'(CAPACITY))))
        else $error("result register holds an impossible status or count");
`endif

endmodule

`default_nettype wire

### sim/tb_positional_list_table_top.sv
// testbench for the positional list table: directed and random commands against a list model
`timescale 1ns / 1ps

module tb_positional_list_table_top;
    import plt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [IDX_W-1:0]    placed;
        logic [IDX_W-1:0]    count;
    } list_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    command = '0;
    logic [IDX_W-1:0]    position = '0;
    logic [IDX_W-1:0]    other_position = '0;
    logic [HANDLE_W-1:0] handle_in = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [IDX_W-1:0]    placed_at;
    logic [IDX_W-1:0]    entry_count;

    // model of the list contents
    logic [HANDLE_W-1:0] list_slots [0:CAPACITY-1];
    int                  list_fill = 0;
    list_reply_t         awaited_replies [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  stall_burst = 0;
    bit  sender_idle_on = 1'b0;
    bit  receiver_idle_on = 1'b0;

    positional_list_table_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .position       (position),
        .other_position (other_position),
        .handle_in      (handle_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .handle_out     (handle_out),
        .placed_at      (placed_at),
        .entry_count    (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall bursts
    always @(posedge clk)
    begin
        if (stall_burst > 0)
        begin
            stall_burst <= stall_burst - 1;
            out_stall <= 1'b1;
        end
        else if (receiver_idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_burst <= $urandom_range(0, 10);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        list_reply_t got;
        list_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, handle_out, placed_at, entry_count};
            if (awaited_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result with nothing pending: status %0d handle %h placed %0d count %0d",
                             got.status, got.handle, got.placed, got.count);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (got.status !== want.status || got.handle !== want.handle ||
                    got.placed !== want.placed || got.count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"expected status %0d handle %h placed %0d count %0d, ",
                                  "got status %0d handle %h placed %0d count %0d"},
                                 want.status, want.handle, want.placed, want.count,
                                 got.status, got.handle, got.placed, got.count);
                end
            end
        end
    end

    task automatic apply_to_list_model(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] pos,
                                       input logic [IDX_W-1:0] opos,
                                       input logic [HANDLE_W-1:0] hin);
        list_reply_t         r;
        logic [HANDLE_W-1:0] held;
        int                  at;
        int                  i;
        r = '0;
        case (cmd)
            CMD_GET:
                if (pos >= list_fill)
                    r.status = ST_BAD_INDEX;
                else
                    r.handle = list_slots[pos];
            CMD_SET:
                if (pos >= list_fill)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    r.handle = list_slots[pos];
                    list_slots[pos] = hin;
                end
            CMD_INSERT:
                if (list_fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    at = (pos > list_fill) ? list_fill : pos;
                    for (i = list_fill; i > at; i--)
                        list_slots[i] = list_slots[i - 1];
                    list_slots[at] = hin;
                    r.placed = IDX_W'(at);
                    list_fill++;
                end
            CMD_REMOVE:
                if (pos >= list_fill)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    r.handle = list_slots[pos];
                    for (i = pos; i + 1 < list_fill; i++)
                        list_slots[i] = list_slots[i + 1];
                    list_fill--;
                end
            CMD_SWAP:
                if (pos >= list_fill || opos >= list_fill)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    held = list_slots[pos];
                    list_slots[pos] = list_slots[opos];
                    list_slots[opos] = held;
                end
            default:
                r.status = ST_OK;
        endcase
        r.count = IDX_W'(list_fill);
        awaited_replies.push_back(r);
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] pos,
                                input logic [IDX_W-1:0] opos, input logic [HANDLE_W-1:0] hin);
        int gap;
        if (sender_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        position <= pos;
        other_position <= opos;
        handle_in <= hin;
        do
            @(posedge clk);
        while (in_stall);
        apply_to_list_model(cmd, pos, opos, hin);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6 && list_fill > 0)
            return IDX_W'($urandom_range(0, list_fill - 1));
        else if (roll < 8)
            return IDX_W'(list_fill + $urandom_range(0, 1));
        else
            return IDX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input int insert_pct, input int remove_pct);
        int roll;
        if ($urandom_range(0, 99) < 3)
        begin
            case ($urandom_range(0, 2))
                0:       return CMD_SPARE_5;
                1:       return CMD_SPARE_6;
                default: return CMD_SPARE_7;
            endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            return CMD_INSERT;
        if (roll < insert_pct + remove_pct)
            return CMD_REMOVE;
        case ($urandom_range(0, 2))
            0:       return CMD_GET;
            1:       return CMD_SET;
            default: return CMD_SWAP;
        endcase
    endfunction

    task automatic send_random_command(input int insert_pct, input int remove_pct);
        logic [CMD_W-1:0]    cmd;
        logic [IDX_W-1:0]    pos;
        logic [IDX_W-1:0]    opos;
        logic [HANDLE_W-1:0] hin;
        cmd = pick_command(insert_pct, remove_pct);
        pos = pick_position();
        opos = pick_position();
        hin = $urandom;
        send_command(cmd, pos, opos, hin);
    endtask

    task automatic test_empty_table();
        send_command(CMD_GET, 8'd0, 8'd0, 32'h0000_0000);
        send_command(CMD_SET, 8'd0, 8'd255, 32'hFFFF_FFFF);
        send_command(CMD_REMOVE, 8'd255, 8'd0, 32'h0000_0000);
        send_command(CMD_SWAP, 8'd0, 8'd0, 32'h0000_0000);
        send_command(CMD_SPARE_5, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_6, 8'd0, 8'd0, 32'h1234_5678);
        send_command(CMD_SPARE_7, 8'd1, 8'd2, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed_ops();
        send_command(CMD_INSERT, 8'd255, 8'd0, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 8'd0, 8'd0, 32'h0000_0000);
        send_command(CMD_INSERT, 8'd1, 8'd0, 32'hA5A5_A5A5);
        send_command(CMD_INSERT, 8'd200, 8'd0, 32'h5A5A_5A5A);
        send_command(CMD_GET, 8'd0, 8'd0, 32'h0);
        send_command(CMD_GET, 8'd3, 8'd0, 32'h0);
        send_command(CMD_GET, 8'd4, 8'd0, 32'h0);
        send_command(CMD_SET, 8'd2, 8'd0, 32'hDEAD_BEEF);
        send_command(CMD_SET, 8'd4, 8'd0, 32'h1111_1111);
        send_command(CMD_SWAP, 8'd0, 8'd3, 32'h0);
        send_command(CMD_SWAP, 8'd1, 8'd1, 32'h0);
        send_command(CMD_SWAP, 8'd0, 8'd4, 32'h0);
        send_command(CMD_SWAP, 8'd255, 8'd0, 32'h0);
        send_command(CMD_REMOVE, 8'd0, 8'd0, 32'h0);
        send_command(CMD_REMOVE, 8'd2, 8'd0, 32'h0);
        send_command(CMD_REMOVE, 8'd5, 8'd0, 32'h0);
        send_command(CMD_GET, 8'd255, 8'd255, 32'h0);
    endtask

    task automatic test_fill_to_capacity();
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        while (list_fill < CAPACITY)
            send_random_command(85, 5);
        send_command(CMD_INSERT, 8'd0, 8'd0, 32'hCAFE_F00D);
        send_command(CMD_GET, IDX_W'(CAPACITY - 1), 8'd0, 32'h0);
        send_command(CMD_GET, IDX_W'(CAPACITY), 8'd0, 32'h0);
        send_command(CMD_SWAP, 8'd0, IDX_W'(CAPACITY - 1), 32'h0);
    endtask

    task automatic test_full_table();
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (30)
            send_random_command(70, 8);
    endtask

    task automatic test_drain();
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        while (list_fill > 0)
            send_random_command(5, 80);
        send_command(CMD_REMOVE, 8'd0, 8'd0, 32'h0);
    endtask

    task automatic test_random_mix();
        int n;
        for (n = 0; n < 250; n++)
        begin
            if (n % 50 == 0)
            begin
                sender_idle_on = 1'($urandom_range(0, 1));
                receiver_idle_on = 1'($urandom_range(0, 1));
            end
            if (n == 125)
                wait_for_results();
            send_random_command(40, 30);
        end
    endtask

    task automatic test_tail_no_idle();
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (60)
            send_random_command(40, 30);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_directed_ops();
        test_fill_to_capacity();
        test_full_table();
        test_drain();
        test_random_mix();
        test_tail_no_idle();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count += awaited_replies.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
hw/rtl/plt_pkg.sv
hw/rtl/plt_cell.sv
hw/rtl/plt_or_tree.sv
hw/rtl/positional_list_table_top.sv
sim/tb_positional_list_table_top.sv
